// ===== rtl/led_fade_current_regulator_assert.svh =====
// Assertion macros for the LED fade and current regulator.
// Included by the top level only; needs no package.
`ifndef LED_FADE_CURRENT_REGULATOR_ASSERT_SVH
`define LED_FADE_CURRENT_REGULATOR_ASSERT_SVH

// Whenever the condition holds at a clock edge, the consequence holds too.
`define LFCR_ASSERT_IMPLIES(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error(msg);

// Whenever the condition holds at a clock edge, the consequence holds at the next clock edge.
`define LFCR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lfcr_pkg.sv =====
// Shared types and constants of the LED fade and current regulator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lfcr_pkg;

	localparam int DUTY_W    = 8;
	localparam int TIMER_W   = 16;
	localparam int ADC_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [DUTY_W-1:0]  START_LEVEL_RST = 8'd16;
	localparam logic [DUTY_W-1:0]  MAX_LEVEL_RST   = 8'd255;
	localparam logic [DUTY_W-1:0]  SLOW_TOP_RST    = 8'd64;
	localparam logic [DUTY_W-1:0]  MID_TOP_RST     = 8'd160;
	localparam logic [TIMER_W-1:0] SLOW_TICKS_RST  = 16'd20;
	localparam logic [TIMER_W-1:0] MID_TICKS_RST   = 16'd10;
	localparam logic [TIMER_W-1:0] FAST_TICKS_RST  = 16'd5;
	localparam logic [ADC_W-1:0]   NOMINAL_RST     = 10'd512;

	localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LEVEL     = 3'd0,
		REG_MAX_LEVEL       = 3'd1,
		REG_SLOW_BAND_TOP   = 3'd2,
		REG_MID_BAND_TOP    = 3'd3,
		REG_SLOW_STEP_TICKS = 3'd4,
		REG_MID_STEP_TICKS  = 3'd5,
		REG_FAST_STEP_TICKS = 3'd6,
		REG_NOMINAL_CURRENT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  start_level;
		logic [DUTY_W-1:0]  max_level;
		logic [DUTY_W-1:0]  slow_band_top;
		logic [DUTY_W-1:0]  mid_band_top;
		logic [TIMER_W-1:0] slow_step_ticks;
		logic [TIMER_W-1:0] mid_step_ticks;
		logic [TIMER_W-1:0] fast_step_ticks;
		logic [ADC_W-1:0]   nominal_current;
	} cfg_t;

	// One timer tick request.
	typedef struct packed {
		logic             key_down;
		logic             sample_valid;
		logic [ADC_W-1:0] sample_value;
	} in_t;

	// One result of a tick.
	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              pwm_running;
		logic              lamp_on;
		logic              start_conversion;
		logic [ADC_W-1:0]  average_current;
		logic              average_ready;
		logic              may_sleep;
	} out_t;

endpackage

`default_nettype wire

// ===== rtl/lfcr_cfg_regs.sv =====
// Configuration register file of the LED fade and current regulator.
// Depends on lfcr_pkg for the register layout and reset values.
`default_nettype none

module lfcr_cfg_regs
	import lfcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_level     <= START_LEVEL_RST;
			cfg_q.max_level       <= MAX_LEVEL_RST;
			cfg_q.slow_band_top   <= SLOW_TOP_RST;
			cfg_q.mid_band_top    <= MID_TOP_RST;
			cfg_q.slow_step_ticks <= SLOW_TICKS_RST;
			cfg_q.mid_step_ticks  <= MID_TICKS_RST;
			cfg_q.fast_step_ticks <= FAST_TICKS_RST;
			cfg_q.nominal_current <= NOMINAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_START_LEVEL:     cfg_q.start_level     <= cfg_data[DUTY_W-1:0];
				REG_MAX_LEVEL:       cfg_q.max_level       <= cfg_data[DUTY_W-1:0];
				REG_SLOW_BAND_TOP:   cfg_q.slow_band_top   <= cfg_data[DUTY_W-1:0];
				REG_MID_BAND_TOP:    cfg_q.mid_band_top    <= cfg_data[DUTY_W-1:0];
				REG_SLOW_STEP_TICKS: cfg_q.slow_step_ticks <= cfg_data[TIMER_W-1:0];
				REG_MID_STEP_TICKS:  cfg_q.mid_step_ticks  <= cfg_data[TIMER_W-1:0];
				REG_FAST_STEP_TICKS: cfg_q.fast_step_ticks <= cfg_data[TIMER_W-1:0];
				REG_NOMINAL_CURRENT: cfg_q.nominal_current <= cfg_data[ADC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/lfcr_tick_core.sv =====
// Tick processing of the LED fade and current regulator: state registers and
// the single-pass next-state logic for fading, key polling and measurement.
// Depends on lfcr_pkg for the request, result and configuration types.
`default_nettype none

module lfcr_tick_core
	import lfcr_pkg::*;
#(
	parameter int SAMPLES_LOG2         = 3,
	parameter int KEY_POLL_TICKS       = 50,
	parameter int MEASURE_PERIOD_TICKS = 100
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cfg_t cfg,
	input  in_t  item,
	output out_t result
);

	localparam int CNT_W = SAMPLES_LOG2 + 2;
	localparam int SUM_W = ADC_W + SAMPLES_LOG2;
	localparam logic [CNT_W-1:0]   COUNT_END    = CNT_W'(2 ** SAMPLES_LOG2);
	localparam logic [TIMER_W-1:0] KEY_PERIOD   = TIMER_W'(KEY_POLL_TICKS);
	localparam logic [TIMER_W-1:0] MEAS_PERIOD  = TIMER_W'(MEASURE_PERIOD_TICKS);

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
		return (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
	endfunction

	// Current state.
	logic [DUTY_W-1:0]  duty_q, target_q;
	logic               lamp_q, pwm_q, held_q, measuring_q;
	logic [TIMER_W-1:0] step_timer_q, key_timer_q, meas_timer_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ADC_W-1:0]   avg_q;

	// Next state.
	logic [DUTY_W-1:0]  duty_d, target_d;
	logic               lamp_d, pwm_d, held_d, measuring_d;
	logic [TIMER_W-1:0] step_timer_d, key_timer_d, meas_timer_d;
	logic [CNT_W-1:0]   count_d;
	logic [SUM_W-1:0]   sum_d;
	logic [ADC_W-1:0]   avg_d;
	logic [TIMER_W-1:0] step_period;
	logic               step_due, start_conv, ready;

	// Step delay depends on the band that the present duty lies in.
	always_comb begin
		if (duty_q <= cfg.slow_band_top) begin
			step_period = cfg.slow_step_ticks;
		end else if (duty_q <= cfg.mid_band_top) begin
			step_period = cfg.mid_step_ticks;
		end else begin
			step_period = cfg.fast_step_ticks;
		end
	end

	// Next state of one tick: fading, then key polling, then measurement.
	always_comb begin
		duty_d       = duty_q;
		target_d     = target_q;
		lamp_d       = lamp_q;
		pwm_d        = pwm_q;
		held_d       = held_q;
		measuring_d  = measuring_q;
		count_d      = count_q;
		sum_d        = sum_q;
		avg_d        = avg_q;
		start_conv   = 1'b0;
		ready        = 1'b0;
		step_timer_d = sat_inc(step_timer_q);
		key_timer_d  = sat_inc(key_timer_q);
		meas_timer_d = sat_inc(meas_timer_q);
		step_due     = step_timer_d >= step_period;

		// Fade one unit toward the target when the step delay has run out.
		if (duty_q != target_q) begin
			if (step_due) begin
				step_timer_d = '0;
			end
			if (target_q < duty_q) begin
				if (step_due) begin
					duty_d = duty_q - 1'b1;
				end
				if (duty_d == '0) begin
					pwm_d = 1'b0;
				end
			end else begin
				if (duty_q == '0) begin
					pwm_d = 1'b1;
				end
				if (step_due) begin
					duty_d = duty_q + 1'b1;
				end
			end
		end

		// Poll the key; a fresh press toggles the lamp.
		if (key_timer_d >= KEY_PERIOD) begin
			key_timer_d = '0;
			if (!held_q && item.key_down) begin
				held_d = 1'b1;
				if (lamp_q) begin
					lamp_d   = 1'b0;
					target_d = '0;
				end else begin
					lamp_d   = 1'b1;
					target_d = (duty_d > cfg.start_level) ? duty_d : cfg.start_level;
				end
			end else if (held_q && !item.key_down) begin
				held_d = 1'b0;
			end
		end

		// Measurement: the first sample is dropped, the rest are averaged.
		if (!measuring_q) begin
			if (meas_timer_d >= MEAS_PERIOD) begin
				meas_timer_d = '0;
				count_d      = '0;
				sum_d        = '0;
				measuring_d  = 1'b1;
				start_conv   = 1'b1;
			end
		end else if (item.sample_valid) begin
			if (count_q != '0) begin
				sum_d = sum_q + SUM_W'(item.sample_value);
			end
			count_d = count_q + 1'b1;
			if (count_d > COUNT_END) begin
				measuring_d  = 1'b0;
				meas_timer_d = '0;
				avg_d        = sum_d[SAMPLES_LOG2 +: ADC_W];
				ready        = 1'b1;
				// Nudge the target toward the nominal current.
				if (lamp_d) begin
					if (avg_d > cfg.nominal_current && target_d != '0) begin
						target_d = target_d - 1'b1;
					end else if (avg_d < cfg.nominal_current && target_d < cfg.max_level) begin
						target_d = target_d + 1'b1;
					end
				end
			end else begin
				start_conv = 1'b1;
			end
		end
	end

	// State registers advance once per processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q       <= '0;
			target_q     <= START_LEVEL_RST;
			lamp_q       <= 1'b1;
			pwm_q        <= 1'b0;
			held_q       <= 1'b0;
			measuring_q  <= 1'b0;
			step_timer_q <= '0;
			key_timer_q  <= '0;
			meas_timer_q <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
		end else if (step) begin
			duty_q       <= duty_d;
			target_q     <= target_d;
			lamp_q       <= lamp_d;
			pwm_q        <= pwm_d;
			held_q       <= held_d;
			measuring_q  <= measuring_d;
			step_timer_q <= step_timer_d;
			key_timer_q  <= key_timer_d;
			meas_timer_q <= meas_timer_d;
			count_q      <= count_d;
			sum_q        <= sum_d;
			avg_q        <= avg_d;
		end
	end

	// Result of the tick being processed.
	always_comb begin
		result.duty             = duty_d;
		result.pwm_running      = pwm_d;
		result.lamp_on          = lamp_d;
		result.start_conversion = start_conv;
		result.average_current  = avg_d;
		result.average_ready    = ready;
		result.may_sleep        = !lamp_d && (duty_d == '0) && !held_d;
	end

endmodule

`default_nettype wire

// ===== rtl/led_fade_current_regulator.sv =====
// LED fade and current regulator. Each request is one timer tick carrying the
// key level and an optional finished ADC sample; each tick yields exactly one
// result with the duty, lamp and measurement status. A request passes through
// an input register and a result register: it waits in the input register until
// the result register is free or being emptied, is then processed, and its
// result is registered and offered on out_item. One tick is accepted every clock
// cycle as long as results are taken. Register writes take effect on the next
// tick and should be made while no tick is in flight.
// Depends on lfcr_pkg, lfcr_cfg_regs, lfcr_tick_core and the assertion header.
`default_nettype none

`include "led_fade_current_regulator_assert.svh"

module led_fade_current_regulator
	import lfcr_pkg::*;
#(
	parameter int SAMPLES_LOG2         = 3,
	parameter int KEY_POLL_TICKS       = 50,
	parameter int MEASURE_PERIOD_TICKS = 100
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_item
);

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	out_t result;
	out_t out_item_q;
	logic out_valid_q;
	logic advance, accept;

	lfcr_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	lfcr_tick_core #(
		.SAMPLES_LOG2        (SAMPLES_LOG2),
		.KEY_POLL_TICKS      (KEY_POLL_TICKS),
		.MEASURE_PERIOD_TICKS(MEASURE_PERIOD_TICKS)
	) u_tick_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.cfg   (cfg),
		.item  (item_s1),
		.result(result)
	);

	// The held tick moves on whenever the result register is free or being emptied.
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// A completed average never coincides with a new conversion request.
	`LFCR_ASSERT_IMPLIES(a_ready_no_conv, clk, arst_n, out_valid_q && out_item_q.average_ready, !out_item_q.start_conversion, "average_ready with start_conversion")
	// Sleep is only allowed with the lamp off and the duty at zero.
	`LFCR_ASSERT_IMPLIES(a_sleep_dark, clk, arst_n, out_valid_q && out_item_q.may_sleep, !out_item_q.lamp_on && out_item_q.duty == '0, "may_sleep while lamp active")
	// The input side stalls only while a tick is held.
	`LFCR_ASSERT_IMPLIES(a_stall_held, clk, arst_n, in_stall, valid_s1, "stall with empty input register")
	// A tick that moves on always leaves a result behind.
	`LFCR_ASSERT_NEXT(a_advance_result, clk, arst_n, advance, out_valid_q, "processed tick lost")

endmodule

`default_nettype wire

// ===== tb/tb_led_fade_current_regulator.sv =====
// Self-checking testbench for the LED fade and current regulator.
// Drives timer ticks and register writes, and checks every result against a tick-level predictor.
// Depends on lfcr_pkg and the led_fade_current_regulator top level.
module tb_led_fade_current_regulator;
	timeunit 1ns;
	timeprecision 1ps;
	import lfcr_pkg::*;

	localparam int SAMPLES_LOG2         = 3;
	localparam int KEY_POLL_TICKS       = 50;
	localparam int MEASURE_PERIOD_TICKS = 100;
	localparam int DRAIN_CYCLES         = 4;
	localparam int HOLD_CYCLES          = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_item;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_item;

	// Predicted lamp state and register copy.
	cfg_t         lamp_cfg;
	logic [7:0]   lamp_duty, lamp_target;
	logic         lamp_on_state, lamp_key_held, lamp_measuring, lamp_pwm;
	logic [15:0]  lamp_step_timer, lamp_key_timer, lamp_measure_timer;
	logic [8:0]   lamp_sample_count;
	logic [17:0]  lamp_sample_sum;
	logic [9:0]   lamp_average;

	out_t pending_results[$];
	int   mismatches;
	int   sender_idle_pct;
	int   recv_idle_pct;
	logic hold_pending;
	logic rand_key;
	int   rand_run_left;

	led_fade_current_regulator #(
		.SAMPLES_LOG2(SAMPLES_LOG2),
		.KEY_POLL_TICKS(KEY_POLL_TICKS),
		.MEASURE_PERIOD_TICKS(MEASURE_PERIOD_TICKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	// Timers count up once per tick and stop at the top value.
	function automatic logic [15:0] count_up(logic [15:0] v);
		return (v == TIMER_MAX) ? v : v + 16'd1;
	endfunction

	function automatic cfg_t make_settings(int start, int max, int slow_top, int mid_top,
			int slow_t, int mid_t, int fast_t, int nominal);
		cfg_t s;
		s.start_level     = start[7:0];
		s.max_level       = max[7:0];
		s.slow_band_top   = slow_top[7:0];
		s.mid_band_top    = mid_top[7:0];
		s.slow_step_ticks = slow_t[15:0];
		s.mid_step_ticks  = mid_t[15:0];
		s.fast_step_ticks = fast_t[15:0];
		s.nominal_current = nominal[9:0];
		return s;
	endfunction

	task automatic load_reset_state();
		lamp_cfg = make_settings(START_LEVEL_RST, MAX_LEVEL_RST, SLOW_TOP_RST, MID_TOP_RST,
			SLOW_TICKS_RST, MID_TICKS_RST, FAST_TICKS_RST, NOMINAL_RST);
		lamp_duty          = '0;
		lamp_target        = lamp_cfg.start_level;
		lamp_on_state      = 1'b1;
		lamp_step_timer    = '0;
		lamp_key_timer     = '0;
		lamp_key_held      = 1'b0;
		lamp_measure_timer = '0;
		lamp_measuring     = 1'b0;
		lamp_sample_count  = '0;
		lamp_sample_sum    = '0;
		lamp_average       = '0;
		lamp_pwm           = 1'b0;
	endtask

	// Advances the predicted lamp by one tick and returns the result it should report.
	function automatic out_t advance_lamp(in_t t);
		out_t       r;
		logic       conv, ready, step_due;
		logic [15:0] band_ticks;
		conv  = 1'b0;
		ready = 1'b0;
		lamp_step_timer    = count_up(lamp_step_timer);
		lamp_key_timer     = count_up(lamp_key_timer);
		lamp_measure_timer = count_up(lamp_measure_timer);

		// Fading: one unit toward the target once the band delay has passed.
		if (lamp_duty <= lamp_cfg.slow_band_top) begin
			band_ticks = lamp_cfg.slow_step_ticks;
		end else if (lamp_duty <= lamp_cfg.mid_band_top) begin
			band_ticks = lamp_cfg.mid_step_ticks;
		end else begin
			band_ticks = lamp_cfg.fast_step_ticks;
		end
		if (lamp_duty != lamp_target) begin
			step_due = lamp_step_timer >= band_ticks;
			if (step_due)
				lamp_step_timer = '0;
			if (lamp_target < lamp_duty) begin
				if (step_due)
					lamp_duty = lamp_duty - 8'd1;
				if (lamp_duty == 0)
					lamp_pwm = 1'b0;
			end else begin
				if (lamp_duty == 0)
					lamp_pwm = 1'b1;
				if (step_due)
					lamp_duty = lamp_duty + 8'd1;
			end
		end

		// Key polling: a fresh press toggles the lamp.
		if (lamp_key_timer >= KEY_POLL_TICKS) begin
			lamp_key_timer = '0;
			if (!lamp_key_held && t.key_down) begin
				lamp_key_held = 1'b1;
				if (lamp_on_state) begin
					lamp_on_state = 1'b0;
					lamp_target   = '0;
				end else begin
					lamp_on_state = 1'b1;
					lamp_target   = (lamp_duty > lamp_cfg.start_level) ? lamp_duty
						: lamp_cfg.start_level;
				end
			end else if (lamp_key_held && !t.key_down) begin
				lamp_key_held = 1'b0;
			end
		end

		// Measurement: the first sample is dropped, the rest are averaged.
		if (!lamp_measuring) begin
			if (lamp_measure_timer >= MEASURE_PERIOD_TICKS) begin
				lamp_measure_timer = '0;
				lamp_sample_count  = '0;
				lamp_sample_sum    = '0;
				lamp_measuring     = 1'b1;
				conv               = 1'b1;
			end
		end else if (t.sample_valid) begin
			if (lamp_sample_count != 0)
				lamp_sample_sum = lamp_sample_sum + 18'(t.sample_value);
			lamp_sample_count = lamp_sample_count + 9'd1;
			if (lamp_sample_count > (1 << SAMPLES_LOG2)) begin
				lamp_measuring     = 1'b0;
				lamp_measure_timer = '0;
				lamp_sample_sum    = lamp_sample_sum >> SAMPLES_LOG2;
				lamp_average       = lamp_sample_sum[9:0];
				ready              = 1'b1;
				if (lamp_on_state) begin
					if (lamp_average > lamp_cfg.nominal_current && lamp_target > 0)
						lamp_target = lamp_target - 8'd1;
					if (lamp_average < lamp_cfg.nominal_current
							&& lamp_target < lamp_cfg.max_level)
						lamp_target = lamp_target + 8'd1;
				end
			end else begin
				conv = 1'b1;
			end
		end

		r.duty             = lamp_duty;
		r.pwm_running      = lamp_pwm;
		r.lamp_on          = lamp_on_state;
		r.start_conversion = conv;
		r.average_current  = lamp_average;
		r.average_ready    = ready;
		r.may_sleep        = !lamp_on_state && lamp_duty == 0 && !lamp_key_held;
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Each accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got duty %0d", $time,
					out_item.duty);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("duty", want.duty, out_item.duty);
				compare_field("pwm_running", want.pwm_running, out_item.pwm_running);
				compare_field("lamp_on", want.lamp_on, out_item.lamp_on);
				compare_field("start_conversion", want.start_conversion,
					out_item.start_conversion);
				compare_field("average_current", want.average_current,
					out_item.average_current);
				compare_field("average_ready", want.average_ready, out_item.average_ready);
				compare_field("may_sleep", want.may_sleep, out_item.may_sleep);
			end
		end
	end

	// Result side: random stalls, or one long hold-off when asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offers one tick request and records its prediction once it is taken.
	task automatic send_tick(in_t t);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(advance_lamp(t));
	endtask

	task automatic wait_until_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Narrow registers get random upper bits, which the block must ignore.
	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		logic [15:0] word;
		word = 16'($urandom_range(65535));
		case (idx) inside
		REG_SLOW_STEP_TICKS, REG_MID_STEP_TICKS, REG_FAST_STEP_TICKS: word = value;
		REG_NOMINAL_CURRENT: word[9:0] = value[9:0];
		default: word[7:0] = value[7:0];
		endcase
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		case (idx)
		REG_START_LEVEL:     lamp_cfg.start_level     = word[7:0];
		REG_MAX_LEVEL:       lamp_cfg.max_level       = word[7:0];
		REG_SLOW_BAND_TOP:   lamp_cfg.slow_band_top   = word[7:0];
		REG_MID_BAND_TOP:    lamp_cfg.mid_band_top    = word[7:0];
		REG_SLOW_STEP_TICKS: lamp_cfg.slow_step_ticks = word;
		REG_MID_STEP_TICKS:  lamp_cfg.mid_step_ticks  = word;
		REG_FAST_STEP_TICKS: lamp_cfg.fast_step_ticks = word;
		REG_NOMINAL_CURRENT: lamp_cfg.nominal_current = word[9:0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(cfg_t s);
		wait_until_idle();
		write_reg(REG_START_LEVEL, 16'(s.start_level));
		write_reg(REG_MAX_LEVEL, 16'(s.max_level));
		write_reg(REG_SLOW_BAND_TOP, 16'(s.slow_band_top));
		write_reg(REG_MID_BAND_TOP, 16'(s.mid_band_top));
		write_reg(REG_SLOW_STEP_TICKS, s.slow_step_ticks);
		write_reg(REG_MID_STEP_TICKS, s.mid_step_ticks);
		write_reg(REG_FAST_STEP_TICKS, s.fast_step_ticks);
		write_reg(REG_NOMINAL_CURRENT, 16'(s.nominal_current));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sample values: mostly close to the nominal current, sometimes anywhere or at the rails.
	function automatic logic [9:0] pick_sample();
		int v;
		case ($urandom_range(3))
		0: v = $urandom_range(1023);
		3: v = $urandom_range(1) ? 1023 : 0;
		default: begin
			v = int'(lamp_cfg.nominal_current) + $urandom_range(16) - 8;
			if (v < 0)
				v = 0;
			if (v > 1023)
				v = 1023;
		end
		endcase
		return v[9:0];
	endfunction

	task automatic send_ticks(int count, logic key, int valid_pct);
		in_t t;
		for (int i = 0; i < count; i++) begin
			t.key_down     = key;
			t.sample_valid = ($urandom_range(99) < valid_pct);
			t.sample_value = pick_sample();
			send_tick(t);
		end
	endtask

	// Release long enough for one poll, then press long enough for one: exactly one toggle.
	task automatic toggle_lamp();
		send_ticks(KEY_POLL_TICKS + 10, 1'b0, 50);
		send_ticks(KEY_POLL_TICKS + 10, 1'b1, 50);
	endtask

	function automatic cfg_t random_settings();
		cfg_t s;
		s = make_settings($urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(3), $urandom_range(3), $urandom_range(3),
			$urandom_range(1023));
		if ($urandom_range(7) == 0)
			s.mid_step_ticks = 16'($urandom_range(65535));
		return s;
	endfunction

	// Every key, valid and sample corner right after reset.
	task automatic test_field_extremes();
		logic [9:0] sample_corners[4];
		in_t        t;
		sample_corners = '{10'h000, 10'h3FF, 10'h155, 10'h2AA};
		for (int k = 0; k < 2; k++) begin
			for (int v = 0; v < 2; v++) begin
				foreach (sample_corners[i]) begin
					t.key_down     = k[0];
					t.sample_valid = v[0];
					t.sample_value = sample_corners[i];
					send_tick(t);
				end
			end
		end
	endtask

	// Switch off at zero delay so the duty reaches zero, then switch on and off again
	// before any step: the PWM stays enabled with the duty at zero.
	task automatic test_pwm_hold();
		apply_settings(make_settings(0, 255, 64, 160, 0, 0, 0, 0));
		if (lamp_on_state)
			toggle_lamp();
		send_ticks(150, 1'b0, 0);
		apply_settings(make_settings(40, 255, 64, 160, 65535, 65535, 65535, 0));
		toggle_lamp();
		toggle_lamp();
		send_ticks(20, 1'b0, 50);
	endtask

	// Switch-on target above the maximum must never be raised by regulation.
	task automatic test_target_above_max();
		apply_settings(make_settings(200, 100, 64, 160, 0, 0, 0, 1023));
		if (lamp_on_state)
			toggle_lamp();
		toggle_lamp();
		send_ticks(300, 1'b0, 80);
	endtask

	// Key held in long runs across polls with the odd short blip; samples in bursts.
	task automatic test_random_ticks(cfg_t s, int count);
		in_t t;
		int  valid_pct;
		apply_settings(s);
		valid_pct = 60;
		for (int i = 0; i < count; i++) begin
			if (rand_run_left == 0) begin
				rand_key      = !rand_key;
				rand_run_left = ($urandom_range(9) == 0) ? $urandom_range(1, 3)
					: $urandom_range(40, 160);
				valid_pct     = $urandom_range(20, 90);
			end
			rand_run_left--;
			t.key_down     = rand_key;
			t.sample_valid = ($urandom_range(99) < valid_pct);
			t.sample_value = pick_sample();
			send_tick(t);
		end
	endtask

	// A long hold-off on the result side while requests keep coming.
	task automatic test_input_backpressure();
		hold_pending = 1'b1;
		test_random_ticks(lamp_cfg, 100);
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_START_LEVEL;
		cfg_data        = '0;
		in_valid        = 1'b0;
		in_item         = '0;
		mismatches      = 0;
		hold_pending    = 1'b0;
		rand_key        = 1'b0;
		rand_run_left   = 0;
		sender_idle_pct = 29;
		recv_idle_pct   = 62;
		load_reset_state();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_pwm_hold();
		test_target_above_max();
		test_random_ticks(make_settings(255, 255, 0, 255, 0, 0, 0, 1023), 90);
		test_random_ticks(random_settings(), 90);

		sender_idle_pct = 62;
		recv_idle_pct   = 29;
		test_random_ticks(make_settings(0, 0, 255, 0, 1, 65535, 65535, 0), 90);
		test_random_ticks(random_settings(), 90);

		sender_idle_pct = 0;
		recv_idle_pct   = 0;
		test_input_backpressure();
		test_random_ticks(random_settings(), 90);
		test_random_ticks(make_settings(START_LEVEL_RST, MAX_LEVEL_RST, SLOW_TOP_RST,
			MID_TOP_RST, 1, 2, 3, NOMINAL_RST), 90);

		wait_until_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
